// ----- sv/dvk_pkg.sv -----
// ----------------------------------------------------------------------------
// dvk_pkg
// Shared types, codes and reset values for the debounced volume key decoder.
// ----------------------------------------------------------------------------
package dvk_pkg;

  // Default number of port bits that can carry key lines.
  localparam int PORT_WIDTH_DEF = 8;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_UP    = 2'd1,
    EV_DOWN  = 2'd2,
    EV_ALBUM = 2'd3
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_MASK         = 3'd0,
    REG_UP_PATTERN       = 3'd1,
    REG_DOWN_PATTERN     = 3'd2,
    REG_BOTH_PATTERN     = 3'd3,
    REG_RELEASED_PATTERN = 3'd4,
    REG_DEBOUNCE_SAMPLES = 3'd5,
    REG_MAX_VOLUME       = 3'd6
  } reg_idx_t;

  localparam logic [7:0] KEY_MASK_RST         = 8'd255;
  localparam logic [7:0] UP_PATTERN_RST       = 8'd1;
  localparam logic [7:0] DOWN_PATTERN_RST     = 8'd2;
  localparam logic [7:0] BOTH_PATTERN_RST     = 8'd0;
  localparam logic [7:0] RELEASED_PATTERN_RST = 8'd3;
  localparam logic [7:0] DEBOUNCE_SAMPLES_RST = 8'd10;
  localparam logic [7:0] MAX_VOLUME_RST       = 8'd31;

  typedef struct packed {
    logic [7:0] key_mask;
    logic [7:0] up_pattern;
    logic [7:0] down_pattern;
    logic [7:0] both_pattern;
    logic [7:0] released_pattern;
    logic [7:0] debounce_samples;
    logic [7:0] max_volume;
  } cfg_t;

  typedef struct packed {
    logic [7:0] last_masked;
    logic [7:0] stable_count;
    logic [7:0] key_state_now;
    logic [7:0] key_state_before;
    logic [7:0] volume;
  } state_t;

  typedef struct packed {
    ev_t        key_event;
    logic [7:0] volume_level;
    logic       volume_saved;
  } result_t;

endpackage

// ----- sv/dvk_in_if.sv -----
// ----------------------------------------------------------------------------
// dvk_in_if
// Sample channel: one polled port byte per beat.
// ----------------------------------------------------------------------------
interface dvk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_sample;

  modport source (output valid, output port_sample, input ready);
  modport sink   (input valid, input port_sample, output ready);
endinterface

// ----- sv/dvk_out_if.sv -----
// ----------------------------------------------------------------------------
// dvk_out_if
// Result channel: key event, volume level and save flag per beat.
// ----------------------------------------------------------------------------
interface dvk_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_event;
  logic [7:0] volume_level;
  logic       volume_saved;

  modport source (output valid, output key_event, output volume_level,
                  output volume_saved, input ready);
  modport sink   (input valid, input key_event, input volume_level,
                  input volume_saved, output ready);
endinterface

// ----- sv/dvk_cfg_if.sv -----
// ----------------------------------------------------------------------------
// dvk_cfg_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface dvk_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/debounced_volume_key_decoder.sv -----
// ----------------------------------------------------------------------------
// debounced_volume_key_decoder
// Debounces two key lines from a polled port byte and turns key releases
// into volume up, volume down and album change events.
// ----------------------------------------------------------------------------
// Every sample beat gives exactly one result beat, in the cycle after it is
// taken. A sample can be taken in every cycle: the whole update is a single
// registered pass from the held state through the masking, the debounce
// compare and the volume step into the result register, and a new sample is
// taken whenever the result register is empty or its beat leaves in the same
// cycle. Registers are written through the configuration channel, which is
// always ready; they should only be changed while no result is pending.
module debounced_volume_key_decoder #(
  parameter int PORT_WIDTH = dvk_pkg::PORT_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  dvk_in_if.sink    in_ch,
  dvk_out_if.source out_ch,
  dvk_cfg_if.sink   cfg_ch
);

  dvk_pkg::cfg_t    cfg_r;
  dvk_pkg::state_t  st_r;
  dvk_pkg::state_t  st_nxt;
  dvk_pkg::result_t res_nxt;
  dvk_pkg::result_t res_r;
  logic             out_valid_r;
  logic             in_acc;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  dvk_step #(
    .PORT_WIDTH (PORT_WIDTH)
  ) u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .sample (in_ch.port_sample),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_mask         <= dvk_pkg::KEY_MASK_RST;
      cfg_r.up_pattern       <= dvk_pkg::UP_PATTERN_RST;
      cfg_r.down_pattern     <= dvk_pkg::DOWN_PATTERN_RST;
      cfg_r.both_pattern     <= dvk_pkg::BOTH_PATTERN_RST;
      cfg_r.released_pattern <= dvk_pkg::RELEASED_PATTERN_RST;
      cfg_r.debounce_samples <= dvk_pkg::DEBOUNCE_SAMPLES_RST;
      cfg_r.max_volume       <= dvk_pkg::MAX_VOLUME_RST;
    end else if (cfg_ch.valid) begin
      case (dvk_pkg::reg_idx_t'(cfg_ch.index))
        dvk_pkg::REG_KEY_MASK:         cfg_r.key_mask         <= cfg_ch.data;
        dvk_pkg::REG_UP_PATTERN:       cfg_r.up_pattern       <= cfg_ch.data;
        dvk_pkg::REG_DOWN_PATTERN:     cfg_r.down_pattern     <= cfg_ch.data;
        dvk_pkg::REG_BOTH_PATTERN:     cfg_r.both_pattern     <= cfg_ch.data;
        dvk_pkg::REG_RELEASED_PATTERN: cfg_r.released_pattern <= cfg_ch.data;
        dvk_pkg::REG_DEBOUNCE_SAMPLES: cfg_r.debounce_samples <= cfg_ch.data;
        dvk_pkg::REG_MAX_VOLUME:       cfg_r.max_volume       <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is only looked at with valid high.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.key_event    = res_r.key_event;
  assign out_ch.volume_level = res_r.volume_level;
  assign out_ch.volume_saved = res_r.volume_saved;

  // An accepted debounce clears the count, so it never sits at its ceiling.
  a_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stable_count != 8'hFF)
    else $error("stable count reached its ceiling");

  a_event_needs_save: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.volume_saved) |-> (res_r.key_event == dvk_pkg::EV_NONE))
    else $error("key event without an accepted debounce");

  a_volume_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !res_nxt.volume_saved) |=> (st_r.volume == $past(st_r.volume)))
    else $error("volume changed on a beat without a debounce");

  a_before_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !res_nxt.volume_saved) |=>
      (st_r.key_state_before == $past(st_r.key_state_before)))
    else $error("previous key state changed without a debounce");

endmodule

// ----- sv/dvk_step.sv -----
// ----------------------------------------------------------------------------
// dvk_step
// Next-state and result logic for one sample: debounce count, key state
// latch and volume stepping.
// ----------------------------------------------------------------------------
module dvk_step #(
  parameter int PORT_WIDTH = dvk_pkg::PORT_WIDTH_DEF
) (
  input  dvk_pkg::cfg_t    cfg,
  input  dvk_pkg::state_t  st,
  input  logic [7:0]       sample,
  output dvk_pkg::state_t  st_nxt,
  output dvk_pkg::result_t res
);

  // Only the low PORT_WIDTH bits of the byte can carry key lines.
  localparam int         PW_CLIP   = (PORT_WIDTH >= 8) ? 8 : PORT_WIDTH;
  localparam logic [8:0] PORT_ONES = (9'd1 << PW_CLIP) - 9'd1;
  localparam logic [7:0] PORT_MASK = PORT_ONES[7:0];

  logic [7:0] masked;
  logic [7:0] count;
  logic       accept;
  logic [7:0] now_new;
  logic       rel;
  logic [8:0] level;
  dvk_pkg::ev_t ev;

  always_comb begin
    masked = sample & cfg.key_mask & PORT_MASK;

    if (masked == st.last_masked) begin
      count = (st.stable_count != 8'hFF) ? st.stable_count + 8'd1 : st.stable_count;
    end else begin
      count = 8'd0;
    end

    accept = (count >= cfg.debounce_samples);

    // A latched both-keys state is left only through the released pattern.
    if (st.key_state_now != cfg.both_pattern || masked == cfg.released_pattern) begin
      now_new = masked;
    end else begin
      now_new = st.key_state_now;
    end

    rel   = (now_new == cfg.released_pattern);
    level = {1'b0, st.volume};
    ev    = dvk_pkg::EV_NONE;
    if (rel && st.key_state_now == cfg.up_pattern) begin
      level = level + 9'd1;
      ev    = dvk_pkg::EV_UP;
    end else if (rel && st.key_state_now == cfg.down_pattern && st.volume != 8'd0) begin
      level = level - 9'd1;
      ev    = dvk_pkg::EV_DOWN;
    end else if (rel && st.key_state_now == cfg.both_pattern) begin
      ev    = dvk_pkg::EV_ALBUM;
    end
    if (level > {1'b0, cfg.max_volume}) begin
      level = {1'b0, cfg.max_volume};
    end

    st_nxt.last_masked = masked;
    if (accept) begin
      st_nxt.stable_count     = 8'd0;
      st_nxt.key_state_before = st.key_state_now;
      st_nxt.key_state_now    = now_new;
      st_nxt.volume           = level[7:0];
      res.key_event           = ev;
      res.volume_saved        = 1'b1;
    end else begin
      st_nxt.stable_count     = count;
      st_nxt.key_state_before = st.key_state_before;
      st_nxt.key_state_now    = st.key_state_now;
      st_nxt.volume           = st.volume;
      res.key_event           = dvk_pkg::EV_NONE;
      res.volume_saved        = 1'b0;
    end
    res.volume_level = st_nxt.volume;
  end

endmodule

// ----- bench/tb_debounced_volume_key_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_volume_key_decoder
// Self-checking bench for the debounced volume key decoder. Polled port bytes
// are streamed in under several register settings. A scoreboard keeps its own
// debounce and volume state, predicts every result beat and compares it field
// by field, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_debounced_volume_key_decoder;

  localparam int CYCLE_LIMIT = 200000;

  class key_event_scoreboard;
    dvk_pkg::cfg_t    regs;
    dvk_pkg::state_t  st;
    dvk_pkg::result_t expected_q[$];
    int               errors;

    function new();
      regs = '{dvk_pkg::KEY_MASK_RST, dvk_pkg::UP_PATTERN_RST, dvk_pkg::DOWN_PATTERN_RST,
               dvk_pkg::BOTH_PATTERN_RST, dvk_pkg::RELEASED_PATTERN_RST,
               dvk_pkg::DEBOUNCE_SAMPLES_RST, dvk_pkg::MAX_VOLUME_RST};
      st = '0;
      errors = 0;
    endfunction

    function void write_reg(dvk_pkg::reg_idx_t idx, logic [7:0] v);
      case (idx)
        dvk_pkg::REG_KEY_MASK:         regs.key_mask = v;
        dvk_pkg::REG_UP_PATTERN:       regs.up_pattern = v;
        dvk_pkg::REG_DOWN_PATTERN:     regs.down_pattern = v;
        dvk_pkg::REG_BOTH_PATTERN:     regs.both_pattern = v;
        dvk_pkg::REG_RELEASED_PATTERN: regs.released_pattern = v;
        dvk_pkg::REG_DEBOUNCE_SAMPLES: regs.debounce_samples = v;
        dvk_pkg::REG_MAX_VOLUME:       regs.max_volume = v;
        default: ;
      endcase
    endfunction

    // Works out the result beat that one accepted sample causes.
    function void note_sample(logic [7:0] port);
      logic [7:0]       masked;
      logic [8:0]       level;
      logic             released;
      dvk_pkg::result_t r;
      masked = port & regs.key_mask;
      if (masked == st.last_masked) begin
        if (st.stable_count != 8'hFF) st.stable_count = st.stable_count + 8'd1;
      end else begin
        st.stable_count = 8'd0;
      end
      st.last_masked = masked;
      r.key_event = dvk_pkg::EV_NONE;
      r.volume_saved = 1'b0;
      if (st.stable_count >= regs.debounce_samples) begin
        level = {1'b0, st.volume};
        st.stable_count = 8'd0;
        st.key_state_before = st.key_state_now;
        // A latched both-keys state is only left through the released pattern.
        if (st.key_state_before != regs.both_pattern || masked == regs.released_pattern)
          st.key_state_now = masked;
        released = (st.key_state_now == regs.released_pattern);
        if (released && st.key_state_before == regs.up_pattern) begin
          level = level + 9'd1;
          r.key_event = dvk_pkg::EV_UP;
        end else if (released && st.key_state_before == regs.down_pattern &&
                     level != 9'd0) begin
          level = level - 9'd1;
          r.key_event = dvk_pkg::EV_DOWN;
        end else if (released && st.key_state_before == regs.both_pattern) begin
          r.key_event = dvk_pkg::EV_ALBUM;
        end
        if (level > {1'b0, regs.max_volume}) level = {1'b0, regs.max_volume};
        st.volume = level[7:0];
        r.volume_saved = 1'b1;
      end
      r.volume_level = st.volume;
      expected_q.push_back(r);
    endfunction

    function void flag(string what, logic [8:0] want, logic [8:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch %0d: %s expected %0d got %0d", errors, what, want, got);
    endfunction

    function void check_result(logic [1:0] ev, logic [7:0] lvl, logic saved);
      dvk_pkg::result_t want;
      if (expected_q.size() == 0) begin
        flag("result beat with nothing pending, level", 9'd0, {1'b0, lvl});
        return;
      end
      want = expected_q.pop_front();
      if (ev !== want.key_event)
        flag("key_event", {7'd0, want.key_event}, {7'd0, ev});
      if (lvl !== want.volume_level)
        flag("volume_level", {1'b0, want.volume_level}, {1'b0, lvl});
      if (saved !== want.volume_saved)
        flag("volume_saved", {8'd0, want.volume_saved}, {8'd0, saved});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  dvk_in_if  in_if ();
  dvk_out_if out_if ();
  dvk_cfg_if cfg_if ();

  debounced_volume_key_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  key_event_scoreboard sb = new();

  int   cycle_count = 0;
  int   samples_sent = 0;
  logic steady = 1'b0;
  int   stall_request = 0;
  int   stall_seen = 0;
  int   stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("debounced_volume_key_decoder verification failed");
      $finish;
    end
  end

  // Results are checked before the sample of the same edge is noted, since a
  // result always belongs to an earlier sample.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.key_event, out_if.volume_level, out_if.volume_saved);
      if (in_if.valid && in_if.ready)
        sb.note_sample(in_if.port_sample);
    end
  end

  // Result side back-pressure, with an occasional long hold-off on request.
  always @(negedge clk) begin
    if (stall_request != stall_seen) begin
      stall_seen = stall_request;
      stall_left = 60;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(99) >= 11);
    end
  end

  task automatic send_sample(logic [7:0] port);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 11) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.port_sample <= port;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_reg(dvk_pkg::reg_idx_t idx, logic [7:0] v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic apply_settings(logic [7:0] mask, logic [7:0] up, logic [7:0] down,
                                logic [7:0] both, logic [7:0] rel, logic [7:0] deb,
                                logic [7:0] maxv);
    set_reg(dvk_pkg::REG_KEY_MASK, mask);
    set_reg(dvk_pkg::REG_UP_PATTERN, up);
    set_reg(dvk_pkg::REG_DOWN_PATTERN, down);
    set_reg(dvk_pkg::REG_BOTH_PATTERN, both);
    set_reg(dvk_pkg::REG_RELEASED_PATTERN, rel);
    set_reg(dvk_pkg::REG_DEBOUNCE_SAMPLES, deb);
    set_reg(dvk_pkg::REG_MAX_VOLUME, maxv);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Holds a key pattern on the port; bits outside the key mask toggle freely.
  task automatic hold_keys(logic [7:0] pattern, int count);
    logic [7:0] m;
    m = sb.regs.key_mask;
    repeat (count) send_sample((pattern & m) | (8'($urandom) & ~m));
  endtask

  // Mostly well-formed presses and releases, with some short bounces and noise.
  task automatic random_phase(int n);
    int first;
    int pick;
    int len;
    first = samples_sent;
    while (samples_sent - first < n) begin
      pick = $urandom_range(9);
      len = int'(sb.regs.debounce_samples) + 1 + $urandom_range(2);
      if ($urandom_range(7) == 0) len = $urandom_range(1, len);
      case (pick)
        0, 1, 2: hold_keys(sb.regs.up_pattern, len);
        3, 4:    hold_keys(sb.regs.down_pattern, len);
        5:       hold_keys(sb.regs.both_pattern, len);
        6, 7, 8: hold_keys(sb.regs.released_pattern, len);
        default: repeat ($urandom_range(1, 3)) send_sample(8'($urandom));
      endcase
    end
  endtask

  initial begin
    logic [7:0] pool [4];
    logic [7:0] m;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.port_sample = 8'd0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = dvk_pkg::REG_KEY_MASK;
    cfg_if.data = 8'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every sample is accepted with a zero debounce count. The state after
    // reset equals the both-keys pattern, so the first samples stay latched.
    apply_settings(8'hFF, 8'h01, 8'h02, 8'h00, 8'h03, 8'd0, 8'd2);
    send_sample(8'hFF);
    send_sample(8'h01);
    send_sample(8'h03);
    repeat (3) begin
      send_sample(8'h01);
      send_sample(8'h03);
    end
    repeat (3) begin
      send_sample(8'h02);
      send_sample(8'h03);
    end
    send_sample(8'h00);
    send_sample(8'h02);
    send_sample(8'h03);
    send_sample(8'h80);
    send_sample(8'h03);
    drain_results();

    // Wide maximum with no idling; push the volume up for the next phase.
    steady = 1'b1;
    apply_settings(8'h03, 8'h01, 8'h02, 8'h00, 8'h03, 8'd1, 8'd255);
    repeat (8) begin
      hold_keys(8'h01, 2);
      hold_keys(8'h03, 2);
    end
    random_phase(20);
    drain_results();
    steady = 1'b0;

    // Lowered maximum on the top bits, with a long hold-off on the results.
    apply_settings(8'hC0, 8'h40, 8'h80, 8'hC0, 8'h00, 8'd3, 8'd4);
    stall_request++;
    random_phase(30);
    drain_results();

    apply_settings(dvk_pkg::KEY_MASK_RST, dvk_pkg::UP_PATTERN_RST,
                   dvk_pkg::DOWN_PATTERN_RST, dvk_pkg::BOTH_PATTERN_RST,
                   dvk_pkg::RELEASED_PATTERN_RST, dvk_pkg::DEBOUNCE_SAMPLES_RST,
                   dvk_pkg::MAX_VOLUME_RST);
    random_phase(20);
    drain_results();

    // Everything masks to zero and all patterns coincide at the longest count,
    // so one run of samples is long enough for exactly one accepted debounce.
    apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd255, 8'd0);
    hold_keys(8'h00, 257);
    drain_results();

    // Random settings drawn from a small pool, so that patterns overlap.
    repeat (3) begin
      m = 8'($urandom);
      foreach (pool[i]) pool[i] = 8'($urandom) & m;
      apply_settings(m, pool[$urandom_range(3)], pool[$urandom_range(3)],
                     pool[$urandom_range(3)], pool[$urandom_range(3)],
                     8'($urandom_range(1, 4)),
                     ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 8)));
      random_phase(15);
      drain_results();
    end

    repeat (5) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("debounced_volume_key_decoder verification clean");
    end else begin
      $display("debounced_volume_key_decoder verification failed");
    end
    $finish;
  end

endmodule
